@@ design/assert_macros.svh @@
// assertion helpers, compiled out for synthesis
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

@@ design/tpts_pkg.sv @@
`default_nettype none
package tpts_pkg;
    localparam int MAX_THREADS = 64;
    localparam int ID_W = $clog2(MAX_THREADS);
    localparam int CNT_W = ID_W + 1;
    localparam int LVL_W = 2;
    localparam int NUM_LVL = 3;
    localparam int QADDR_W = LVL_W + ID_W;

    localparam logic [2:0] OP_ADD_READY = 3'd0;
    localparam logic [2:0] OP_ADD_WAITING = 3'd1;
    localparam logic [2:0] OP_ADD_LOCKED = 3'd2;
    localparam logic [2:0] OP_UNLOCK = 3'd3;
    localparam logic [2:0] OP_DISPATCH = 3'd4;
    localparam logic [2:0] OP_YIELD = 3'd5;
    localparam logic [2:0] OP_FINISH = 3'd6;
    localparam logic [2:0] OP_QUERY = 3'd7;

    localparam logic [2:0] ST_OK = 3'd0;
    localparam logic [2:0] ST_EMPTY = 3'd1;
    localparam logic [2:0] ST_BUSY = 3'd2;
    localparam logic [2:0] ST_NOTFOUND = 3'd3;
    localparam logic [2:0] ST_NONE = 3'd4;
    localparam logic [2:0] ST_DUP = 3'd5;

    localparam logic [1:0] PLACE_ABSENT = 2'd0;
    localparam logic [1:0] PLACE_READY = 2'd1;
    localparam logic [1:0] PLACE_WAITING = 2'd2;
    localparam logic [1:0] PLACE_LOCKED = 2'd3;

    localparam logic [1:0] PRIO_LOW = 2'd2;

    typedef logic [ID_W-1:0] id_t;
endpackage
`default_nettype wire

@@ design/three_level_priority_thread_scheduler.sv @@
// channel  | handshake             | payload
// input    | in_valid / in_stall   | operation, thread_id, priority_req, target_id
// output   | out_valid / out_stall | status, chosen_id, running_valid, thread_exists, has_waiter
// one request at a time: add, unlock, query and yield pass through S_RD and S_DONE, dispatch
// may add S_POPRQ and S_POPD, and finish may add S_WAKE ahead of them, then S_IDLE takes the
// next transfer; thread, waiter and queue memory reads are registered, updated and written back
// in_stall is high from a transfer until its result enters the output register
// async active-low reset empties the queues and the running slot; no clearing pass
// a stalled result holds the block before its output register loads
`default_nettype none
`include "assert_macros.svh"
module three_level_priority_thread_scheduler (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      in_valid,
    output logic                           in_stall,
    input  wire logic [2:0]                operation,
    input  wire logic [tpts_pkg::ID_W-1:0] thread_id,
    input  wire logic [1:0]                priority_req,
    input  wire logic [tpts_pkg::ID_W-1:0] target_id,
    output logic                           out_valid,
    input  wire logic                      out_stall,
    output logic [2:0]                     status,
    output logic [tpts_pkg::ID_W-1:0]      chosen_id,
    output logic                           running_valid,
    output logic                           thread_exists,
    output logic                           has_waiter
);
    import tpts_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RD = 3'd1;
    localparam logic [2:0] S_WAKE = 3'd2;
    localparam logic [2:0] S_POPRQ = 3'd3;
    localparam logic [2:0] S_POPD = 3'd4;
    localparam logic [2:0] S_DONE = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] op_reg;
    id_t tid_reg, tgt_reg, run_id_reg, w_reg, taddr_reg;
    logic [1:0] prio_reg;
    logic run_v_reg;
    logic [2:0] res_status_reg;
    id_t res_chosen_reg;
    logic res_exists_reg, res_waiter_reg;
    id_t head_reg [NUM_LVL];
    logic [CNT_W-1:0] cnt_reg [NUM_LVL];
    logic [MAX_THREADS-1:0] tvalid_reg, wvalid_reg;
    logic out_valid_reg;
    logic [2:0] status_reg;
    id_t chosen_reg;
    logic running_reg, exists_reg, waiter_reg;

    logic accept;
    logic out_load;
    logic [3:0] tram_rdata, tram_wdata;
    id_t tram_raddr, tram_waddr, wram_rdata;
    logic tram_we, wram_we, qram_we;
    logic [QADDR_W-1:0] qram_raddr, qram_waddr;
    id_t qram_rdata;
    logic [1:0] t_place, t_prio;
    logic t_occupied;
    logic [1:0] push_lvl, best_lvl;
    logic any_ready;
    id_t push_id;

    assign accept = in_valid && !in_stall;
    assign in_stall = (state_reg != S_IDLE);
    assign out_load = (state_reg == S_DONE) && (!out_valid_reg || !out_stall);

    // place reads as absent until the entry has been written
    assign t_place = tvalid_reg[taddr_reg] ? tram_rdata[1:0] : PLACE_ABSENT;
    assign t_prio = tram_rdata[3:2];
    assign t_occupied = (t_place != PLACE_ABSENT) || (run_v_reg && run_id_reg == tid_reg);

    assign any_ready = (cnt_reg[0] != '0) || (cnt_reg[1] != '0) || (cnt_reg[2] != '0);
    always_comb
    begin
        if (cnt_reg[0] != '0)
        begin
            best_lvl = 2'd0;
        end
        else if (cnt_reg[1] != '0)
        begin
            best_lvl = 2'd1;
        end
        else
        begin
            best_lvl = 2'd2;
        end
    end

    always_comb
    begin
        if (state_reg == S_RD)
        begin
            tram_raddr = wram_rdata;
        end
        else if (operation == OP_YIELD)
        begin
            tram_raddr = run_id_reg;
        end
        else
        begin
            tram_raddr = thread_id;
        end
    end

    // writes to the thread table, the waiter memory and the queue memory
    always_comb
    begin
        tram_we = 1'b0;
        tram_waddr = tid_reg;
        tram_wdata = {prio_reg, PLACE_READY};
        qram_we = 1'b0;
        push_lvl = prio_reg;
        push_id = tid_reg;
        wram_we = 1'b0;
        if (state_reg == S_RD)
        begin
            case (op_reg)
                OP_ADD_READY:
                begin
                    tram_we = !t_occupied;
                    qram_we = !t_occupied;
                end
                OP_ADD_LOCKED:
                begin
                    tram_we = !t_occupied;
                    tram_wdata = {prio_reg, PLACE_LOCKED};
                end
                OP_ADD_WAITING:
                begin
                    tram_we = !t_occupied && !wvalid_reg[tgt_reg];
                    wram_we = tram_we;
                    tram_wdata = {prio_reg, PLACE_WAITING};
                end
                OP_YIELD:
                begin
                    tram_we = run_v_reg;
                    qram_we = run_v_reg;
                    tram_waddr = run_id_reg;
                    tram_wdata = {t_prio, PLACE_READY};
                    push_lvl = t_prio;
                    push_id = run_id_reg;
                end
                default:
                begin
                end
            endcase
        end
        else if (state_reg == S_WAKE)
        begin
            tram_we = 1'b1;
            qram_we = 1'b1;
            tram_waddr = w_reg;
            tram_wdata = {t_prio, PLACE_READY};
            push_lvl = t_prio;
            push_id = w_reg;
        end
    end

    assign qram_waddr = {push_lvl, head_reg[push_lvl] + cnt_reg[push_lvl][ID_W-1:0]};
    assign qram_raddr = {best_lvl, head_reg[best_lvl]};

    tpts_ram #(.WIDTH(4), .DEPTH(MAX_THREADS)) u_thread_ram (
        .clk(clk), .we(tram_we), .waddr(tram_waddr), .wdata(tram_wdata),
        .raddr(tram_raddr), .rdata(tram_rdata)
    );

    tpts_ram #(.WIDTH(ID_W), .DEPTH(MAX_THREADS)) u_waiter_ram (
        .clk(clk), .we(wram_we), .waddr(tgt_reg), .wdata(tid_reg),
        .raddr(run_id_reg), .rdata(wram_rdata)
    );

    tpts_ram #(.WIDTH(ID_W), .DEPTH(NUM_LVL * MAX_THREADS)) u_queue_ram (
        .clk(clk), .we(qram_we), .waddr(qram_waddr), .wdata(push_id),
        .raddr(qram_raddr), .rdata(qram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            run_v_reg <= 1'b0;
            run_id_reg <= '0;
            tvalid_reg <= '0;
            wvalid_reg <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_LVL; i++)
            begin
                head_reg[i] <= '0;
                cnt_reg[i] <= '0;
            end
        end
        else
        begin
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            if (qram_we)
            begin
                cnt_reg[push_lvl] <= cnt_reg[push_lvl] + 1'b1;
            end
            if (tram_we)
            begin
                tvalid_reg[tram_waddr] <= 1'b1;
            end
            if (wram_we)
            begin
                wvalid_reg[tgt_reg] <= 1'b1;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        state_reg <= S_RD;
                    end
                end
                S_RD:
                begin
                    state_reg <= S_DONE;
                    case (op_reg)
                        OP_UNLOCK:
                        begin
                            if (t_place == PLACE_LOCKED)
                            begin
                                tvalid_reg[tid_reg] <= 1'b0;
                            end
                        end
                        OP_DISPATCH:
                        begin
                            if (!run_v_reg)
                            begin
                                state_reg <= S_POPRQ;
                            end
                        end
                        OP_YIELD:
                        begin
                            run_v_reg <= 1'b0;
                        end
                        OP_FINISH:
                        begin
                            if (run_v_reg)
                            begin
                                run_v_reg <= 1'b0;
                                if (wvalid_reg[run_id_reg])
                                begin
                                    wvalid_reg[run_id_reg] <= 1'b0;
                                    state_reg <= S_WAKE;
                                end
                                else
                                begin
                                    state_reg <= S_POPRQ;
                                end
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
                S_WAKE:
                begin
                    state_reg <= S_POPRQ;
                end
                S_POPRQ:
                begin
                    if (any_ready)
                    begin
                        head_reg[best_lvl] <= head_reg[best_lvl] + 1'b1;
                        cnt_reg[best_lvl] <= cnt_reg[best_lvl] - 1'b1;
                        state_reg <= S_POPD;
                    end
                    else
                    begin
                        state_reg <= S_DONE;
                    end
                end
                S_POPD:
                begin
                    run_v_reg <= 1'b1;
                    run_id_reg <= qram_rdata;
                    tvalid_reg[qram_rdata] <= 1'b0;
                    state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    if (out_load)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // request fields and the result being built
    always_ff @(posedge clk)
    begin
        taddr_reg <= tram_raddr;
        case (state_reg)
            S_IDLE:
            begin
                op_reg <= operation;
                tid_reg <= thread_id;
                tgt_reg <= target_id;
                prio_reg <= (priority_req > PRIO_LOW) ? PRIO_LOW : priority_req;
                res_status_reg <= ST_OK;
                res_chosen_reg <= '0;
                res_exists_reg <= 1'b0;
                res_waiter_reg <= 1'b0;
            end
            S_RD:
            begin
                w_reg <= wram_rdata;
                case (op_reg)
                    OP_ADD_READY, OP_ADD_LOCKED:
                    begin
                        if (t_occupied)
                        begin
                            res_status_reg <= ST_DUP;
                        end
                    end
                    OP_ADD_WAITING:
                    begin
                        if (t_occupied || wvalid_reg[tgt_reg])
                        begin
                            res_status_reg <= ST_DUP;
                        end
                    end
                    OP_UNLOCK:
                    begin
                        if (t_place == PLACE_LOCKED)
                        begin
                            res_chosen_reg <= tid_reg;
                        end
                        else
                        begin
                            res_status_reg <= ST_NOTFOUND;
                        end
                    end
                    OP_DISPATCH:
                    begin
                        if (run_v_reg)
                        begin
                            res_status_reg <= ST_BUSY;
                        end
                    end
                    OP_YIELD:
                    begin
                        if (run_v_reg)
                        begin
                            res_chosen_reg <= run_id_reg;
                        end
                        else
                        begin
                            res_status_reg <= ST_NONE;
                        end
                    end
                    OP_FINISH:
                    begin
                        if (!run_v_reg)
                        begin
                            res_status_reg <= ST_NONE;
                        end
                    end
                    OP_QUERY:
                    begin
                        res_exists_reg <= (t_place != PLACE_ABSENT);
                        res_waiter_reg <= wvalid_reg[tid_reg];
                    end
                    default:
                    begin
                    end
                endcase
            end
            S_POPRQ:
            begin
                if (!any_ready)
                begin
                    res_status_reg <= ST_EMPTY;
                end
            end
            S_POPD:
            begin
                res_chosen_reg <= qram_rdata;
            end
            default:
            begin
            end
        endcase
        if (out_load)
        begin
            status_reg <= res_status_reg;
            chosen_reg <= res_chosen_reg;
            running_reg <= run_v_reg;
            exists_reg <= res_exists_reg;
            waiter_reg <= res_waiter_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign status = status_reg;
    assign chosen_id = chosen_reg;
    assign running_valid = running_reg;
    assign thread_exists = exists_reg;
    assign has_waiter = waiter_reg;

    logic [CNT_W+1:0] cnt_sum;
    assign cnt_sum = {2'b00, cnt_reg[0]} + {2'b00, cnt_reg[1]} + {2'b00, cnt_reg[2]};

    `ASSERT_IMPL(a_queue_total, clk, rst_n, 1'b1, cnt_sum <= (CNT_W+2)'(MAX_THREADS))
    `ASSERT_IMPL(a_run_from_pop, clk, rst_n, $rose(run_v_reg), $past(state_reg) == S_POPD)
    `ASSERT_NEXT(a_busy_after_accept, clk, rst_n, accept, state_reg == S_RD)
    `ASSERT_IMPL(a_single_push, clk, rst_n, qram_we, state_reg == S_RD || state_reg == S_WAKE)
endmodule
`default_nettype wire

@@ design/tpts_ram.sv @@
`default_nettype none
module tpts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]              rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

@@ test/testbench.sv @@
`timescale 1ns / 1ps
module testbench;
    import tpts_pkg::*;

    typedef struct packed {
        logic [2:0]      status;
        logic [ID_W-1:0] chosen_id;
        logic            running_valid;
        logic            thread_exists;
        logic            has_waiter;
    } sched_result_t;

    logic            clk;
    logic            rst_n;
    logic            in_valid;
    logic            in_stall;
    logic [2:0]      operation;
    logic [ID_W-1:0] thread_id;
    logic [1:0]      priority_req;
    logic [ID_W-1:0] target_id;
    logic            out_valid;
    logic            out_stall;
    logic [2:0]      status;
    logic [ID_W-1:0] chosen_id;
    logic            running_valid;
    logic            thread_exists;
    logic            has_waiter;

    // shadow scheduler state
    id_t             ready_fifo [NUM_LVL][$];
    logic [1:0]      place_tab [MAX_THREADS];
    logic [1:0]      prio_tab [MAX_THREADS];
    logic            waiter_vld [MAX_THREADS];
    id_t             waiter_tab [MAX_THREADS];
    logic            run_vld;
    id_t             run_id;

    sched_result_t   pending_results [$];
    int              errors;
    int              idle_cycles;
    bit              hold_req;

    three_level_priority_thread_scheduler dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .operation     (operation),
        .thread_id     (thread_id),
        .priority_req  (priority_req),
        .target_id     (target_id),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .status        (status),
        .chosen_id     (chosen_id),
        .running_valid (running_valid),
        .thread_exists (thread_exists),
        .has_waiter    (has_waiter)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic bit occupied(id_t id);
        return place_tab[id] != PLACE_ABSENT || (run_vld && run_id == id);
    endfunction

    function automatic logic [2:0] start_best(output id_t picked);
        picked = '0;
        for (int lvl = 0; lvl < NUM_LVL; lvl++)
        begin
            if (ready_fifo[lvl].size() != 0)
            begin
                picked = ready_fifo[lvl].pop_front();
                place_tab[picked] = PLACE_ABSENT;
                run_id = picked;
                run_vld = 1'b1;
                return ST_OK;
            end
        end
        return ST_EMPTY;
    endfunction

    function automatic sched_result_t schedule_step(logic [2:0] op, id_t tid,
                                                    logic [1:0] prio_in, id_t tgt);
        sched_result_t r;
        logic [1:0]    prio;
        id_t           picked;
        id_t           w;
        r = '0;
        prio = (prio_in > PRIO_LOW) ? PRIO_LOW : prio_in;
        case (op)
            OP_ADD_READY, OP_ADD_LOCKED:
            begin
                if (occupied(tid))
                    r.status = ST_DUP;
                else
                begin
                    prio_tab[tid] = prio;
                    if (op == OP_ADD_READY)
                    begin
                        place_tab[tid] = PLACE_READY;
                        ready_fifo[prio].push_back(tid);
                    end
                    else
                        place_tab[tid] = PLACE_LOCKED;
                end
            end
            OP_ADD_WAITING:
            begin
                if (occupied(tid) || waiter_vld[tgt])
                    r.status = ST_DUP;
                else
                begin
                    prio_tab[tid] = prio;
                    place_tab[tid] = PLACE_WAITING;
                    waiter_vld[tgt] = 1'b1;
                    waiter_tab[tgt] = tid;
                end
            end
            OP_UNLOCK:
            begin
                if (place_tab[tid] != PLACE_LOCKED)
                    r.status = ST_NOTFOUND;
                else
                begin
                    place_tab[tid] = PLACE_ABSENT;
                    r.chosen_id = tid;
                end
            end
            OP_DISPATCH:
            begin
                if (run_vld)
                    r.status = ST_BUSY;
                else
                begin
                    r.status = start_best(picked);
                    r.chosen_id = picked;
                end
            end
            OP_YIELD:
            begin
                if (!run_vld)
                    r.status = ST_NONE;
                else
                begin
                    r.chosen_id = run_id;
                    run_vld = 1'b0;
                    place_tab[run_id] = PLACE_READY;
                    ready_fifo[prio_tab[run_id]].push_back(run_id);
                end
            end
            OP_FINISH:
            begin
                if (!run_vld)
                    r.status = ST_NONE;
                else
                begin
                    run_vld = 1'b0;
                    if (waiter_vld[run_id])
                    begin
                        w = waiter_tab[run_id];
                        waiter_vld[run_id] = 1'b0;
                        place_tab[w] = PLACE_READY;
                        ready_fifo[prio_tab[w]].push_back(w);
                    end
                    r.status = start_best(picked);
                    r.chosen_id = picked;
                end
            end
            default:
            begin
                r.thread_exists = place_tab[tid] != PLACE_ABSENT;
                r.has_waiter = waiter_vld[tid];
            end
        endcase
        r.running_valid = run_vld;
        return r;
    endfunction

    // one transfer on the input side, then a random gap that may be zero
    task automatic send_item(logic [2:0] op, id_t tid, logic [1:0] prio, id_t tgt);
        int gap;
        in_valid <= 1'b1;
        operation <= op;
        thread_id <= tid;
        priority_req <= prio;
        target_id <= tgt;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pending_results.push_back(schedule_step(op, tid, prio, tgt));
        gap = ($urandom_range(0, 9) < 6) ? 0 :
              ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic wait_drained();
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_directed();
        send_item(OP_DISPATCH, 6'd0, 2'd0, 6'd0);
        send_item(OP_YIELD, 6'd0, 2'd0, 6'd0);
        send_item(OP_FINISH, 6'd0, 2'd0, 6'd0);
        send_item(OP_ADD_READY, 6'd63, 2'd3, 6'd0);
        send_item(OP_ADD_READY, 6'd0, 2'd1, 6'd0);
        send_item(OP_ADD_READY, 6'd21, 2'd0, 6'd0);
        send_item(OP_ADD_READY, 6'd21, 2'd2, 6'd0);
        send_item(OP_ADD_WAITING, 6'd42, 2'd2, 6'd21);
        send_item(OP_ADD_WAITING, 6'd7, 2'd0, 6'd21);
        send_item(OP_ADD_LOCKED, 6'd5, 2'd1, 6'd0);
        send_item(OP_ADD_LOCKED, 6'd5, 2'd1, 6'd0);
        send_item(OP_QUERY, 6'd21, 2'd0, 6'd0);
        send_item(OP_QUERY, 6'd5, 2'd3, 6'd63);
        send_item(OP_DISPATCH, 6'd0, 2'd0, 6'd0);
        send_item(OP_DISPATCH, 6'd0, 2'd0, 6'd0);
        send_item(OP_ADD_READY, 6'd21, 2'd0, 6'd0);
        send_item(OP_YIELD, 6'd0, 2'd0, 6'd0);
        send_item(OP_DISPATCH, 6'd0, 2'd0, 6'd0);
        send_item(OP_FINISH, 6'd0, 2'd0, 6'd0);
        send_item(OP_UNLOCK, 6'd5, 2'd0, 6'd0);
        send_item(OP_UNLOCK, 6'd5, 2'd0, 6'd0);
        send_item(OP_FINISH, 6'd0, 2'd0, 6'd0);
        send_item(OP_FINISH, 6'd0, 2'd0, 6'd0);
        send_item(OP_FINISH, 6'd0, 2'd0, 6'd0);
        send_item(OP_QUERY, 6'd63, 2'd0, 6'd0);
    endtask

    task automatic send_random(int count);
        int   pick;
        logic [2:0] op;
        id_t  tid;
        id_t  tgt;
        for (int n = 0; n < count; n++)
        begin
            pick = $urandom_range(0, 99);
            op = (pick < 25) ? OP_ADD_READY : (pick < 35) ? OP_ADD_WAITING :
                 (pick < 43) ? OP_ADD_LOCKED : (pick < 50) ? OP_UNLOCK :
                 (pick < 68) ? OP_DISPATCH : (pick < 76) ? OP_YIELD :
                 (pick < 90) ? OP_FINISH : OP_QUERY;
            if ($urandom_range(0, 3) == 0)
            begin
                tid = id_t'($urandom_range(0, 63));
                tgt = id_t'($urandom_range(0, 63));
            end
            else
            begin
                // a small pool keeps duplicates and joins frequent
                tid = id_t'($urandom_range(0, 15));
                tgt = id_t'($urandom_range(0, 15));
            end
            send_item(op, tid, 2'($urandom_range(0, 3)), tgt);
        end
    endtask

    task automatic test_random();
        send_random(1350);
    endtask

    task automatic test_backpressure();
        hold_req = 1'b1;
        send_random(40);
    endtask

    task automatic test_pause();
        in_valid <= 1'b0;
        wait_drained();
        send_random(30);
    endtask

    // receiver idling, with one long hold-off on request
    initial
    begin
        int gap;
        out_stall = 1'b0;
        forever
        begin
            if (hold_req)
            begin
                out_stall <= 1'b1;
                repeat (300) @(posedge clk);
                hold_req = 1'b0;
            end
            else
            begin
                gap = ($urandom_range(0, 9) < 6) ? 0 :
                      ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40)
                                                   : $urandom_range(1, 3);
                out_stall <= (gap > 0);
                repeat (gap > 0 ? gap : $urandom_range(1, 8)) @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        sched_result_t got;
        sched_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            got = {status, chosen_id, running_valid, thread_exists, has_waiter};
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result %h", $realtime, got);
                errors++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (got.status !== want.status)
                begin
                    $display("%0t: status expected %0d actual %0d", $realtime,
                             want.status, got.status);
                    errors++;
                end
                if (got.chosen_id !== want.chosen_id)
                begin
                    $display("%0t: chosen_id expected %0d actual %0d", $realtime,
                             want.chosen_id, got.chosen_id);
                    errors++;
                end
                if (got.running_valid !== want.running_valid)
                begin
                    $display("%0t: running_valid expected %0d actual %0d", $realtime,
                             want.running_valid, got.running_valid);
                    errors++;
                end
                if (got.thread_exists !== want.thread_exists)
                begin
                    $display("%0t: thread_exists expected %0d actual %0d", $realtime,
                             want.thread_exists, got.thread_exists);
                    errors++;
                end
                if (got.has_waiter !== want.has_waiter)
                begin
                    $display("%0t: has_waiter expected %0d actual %0d", $realtime,
                             want.has_waiter, got.has_waiter);
                    errors++;
                end
            end
        end
    end

    // cycles with no transfer on either side
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 5000)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial
    begin
        errors = 0;
        idle_cycles = 0;
        hold_req = 1'b0;
        run_vld = 1'b0;
        run_id = '0;
        for (int i = 0; i < MAX_THREADS; i++)
        begin
            place_tab[i] = PLACE_ABSENT;
            prio_tab[i] = '0;
            waiter_vld[i] = 1'b0;
            waiter_tab[i] = '0;
        end
        rst_n = 1'b0;
        in_valid = 1'b0;
        operation = OP_QUERY;
        thread_id = '0;
        priority_req = '0;
        target_id = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random();
        test_backpressure();
        test_pause();
        in_valid <= 1'b0;
        wait_drained();
        repeat (20) @(posedge clk);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
